// ===== sv/cvom_pkg.sv =====
// ----------------------------------------------------------------------------
// cvom_pkg
// Types and constants shared by the camera view / ortho matrix blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package cvom_pkg;

  localparam int EntryCount  = 16;
  localparam int CordicSteps = 24;
  localparam int AngW        = 36;
  localparam int XyW         = 34;
  localparam int VW          = 52;
  localparam int NumW        = 68;
  localparam int DenW        = 37;
  localparam int RemW        = 38;
  localparam int QW          = 33;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [XyW-1:0]  xy_t;
  typedef logic [11:0][VW-1:0]    cvom_mat_t;

  localparam ang_t Q30Pi     = 36'sd3373259426;
  localparam ang_t Q30HalfPi = 36'sd1686629713;
  localparam ang_t Q30TwoPi  = 36'sd6746518852;
  localparam xy_t  CordicGain = 34'sd652032874;

  localparam ang_t AtanTab [CordicSteps] = '{
    36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
    36'sd33543516,  36'sd16775851,  36'sd8388437,   36'sd4194283,   36'sd2097149,
    36'sd1048576,   36'sd524288,    36'sd262144,    36'sd131072,    36'sd65536,
    36'sd32768,     36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
    36'sd1024,      36'sd512,       36'sd256,       36'sd128
  };

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] cam_yaw;
    logic signed [15:0] cam_pitch;
    logic [31:0]        view_width;
    logic [15:0]        view_aspect;
  } cvom_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] entry_value;
    logic               divide_error;
    logic               last_entry;
  } cvom_out_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic               byp;
    logic signed [31:0] byp_val;
    logic               err;
    logic               last;
    logic               addone;
  } cvom_tag_t;

endpackage

`default_nettype wire

// ===== sv/cvom_cordic.sv =====
// ----------------------------------------------------------------------------
// cvom_cordic
// Two-lane pipelined CORDIC: sine and cosine of yaw and pitch in Q4.30.
// ----------------------------------------------------------------------------
`default_nettype none

module cvom_cordic import cvom_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  cvom_in_t item_i,
  output logic     valid_o,
  output cvom_in_t item_o,
  output xy_t      sin_yaw_o,
  output xy_t      cos_yaw_o,
  output xy_t      sin_pitch_o,
  output xy_t      cos_pitch_o
);

  localparam int Depth = CordicSteps + 3;

  logic [Depth-1:0] vld_q;
  cvom_in_t         itm_q [Depth];
  ang_t             raw   [2];
  ang_t             red_q [2];
  ang_t             a_q   [CordicSteps+1][2];
  logic             flip_q [CordicSteps+1][2];
  xy_t              x_q   [CordicSteps+1][2];
  xy_t              y_q   [CordicSteps+1][2];
  xy_t              s_q   [2];
  xy_t              c_q   [2];

  always_comb begin
    raw[0] = {{(AngW-33){item_i.cam_yaw[15]}}, item_i.cam_yaw, 17'b0};
    raw[1] = {{(AngW-33){item_i.cam_pitch[15]}}, item_i.cam_pitch, 17'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    itm_q[0] <= item_i;
    for (int s = 1; s < Depth; s++) begin
      itm_q[s] <= itm_q[s-1];
    end
    for (int l = 0; l < 2; l++) begin
      if (raw[l] > Q30Pi) begin
        red_q[l] <= raw[l] - Q30TwoPi;
      end else if (raw[l] < -Q30Pi) begin
        red_q[l] <= raw[l] + Q30TwoPi;
      end else begin
        red_q[l] <= raw[l];
      end
      x_q[0][l] <= CordicGain;
      y_q[0][l] <= '0;
      if (red_q[l] > Q30HalfPi) begin
        a_q[0][l]    <= Q30Pi - red_q[l];
        flip_q[0][l] <= 1'b1;
      end else if (red_q[l] < -Q30HalfPi) begin
        a_q[0][l]    <= -Q30Pi - red_q[l];
        flip_q[0][l] <= 1'b1;
      end else begin
        a_q[0][l]    <= red_q[l];
        flip_q[0][l] <= 1'b0;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        flip_q[i+1][l] <= flip_q[i][l];
        if (!a_q[i][l][AngW-1]) begin
          x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
          y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
          a_q[i+1][l] <= a_q[i][l] - AtanTab[i];
        end else begin
          x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
          y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
          a_q[i+1][l] <= a_q[i][l] + AtanTab[i];
        end
      end
      s_q[l] <= y_q[CordicSteps][l];
      c_q[l] <= flip_q[CordicSteps][l] ? -x_q[CordicSteps][l] : x_q[CordicSteps][l];
    end
  end

  assign valid_o     = vld_q[Depth-1];
  assign item_o      = itm_q[Depth-1];
  assign sin_yaw_o   = s_q[0];
  assign cos_yaw_o   = c_q[0];
  assign sin_pitch_o = s_q[1];
  assign cos_pitch_o = c_q[1];

endmodule

`default_nettype wire

// ===== sv/cvom_rot.sv =====
// ----------------------------------------------------------------------------
// cvom_rot
// Rotation matrix and translation terms of the view matrix, five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cvom_rot import cvom_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cvom_in_t  item_i,
  input  xy_t       sin_yaw_i,
  input  xy_t       cos_yaw_i,
  input  xy_t       sin_pitch_i,
  input  xy_t       cos_pitch_i,
  output logic      valid_o,
  output cvom_in_t  item_o,
  output cvom_mat_t mat_o
);

  localparam int Depth = 5;
  localparam int PrW   = 2 * XyW;
  localparam int DpW   = XyW + 32;
  localparam int DotW  = DpW + 2;

  logic [Depth-1:0]   vld_q;
  cvom_in_t           itm_q [Depth];
  logic signed [PrW-1:0] pr_q [4];
  xy_t                sy_q, cy_q, sp_q, cp_q;
  xy_t                rot_q  [3][3];
  xy_t                rot3_q [3][3];
  xy_t                rot4_q [3][3];
  logic signed [DpW-1:0]  dp_q  [3][3];
  logic signed [DotW-1:0] dot_q [3];
  logic signed [PrW-1:0]  prr   [4];
  logic signed [31:0]     pos   [3];
  logic signed [DotW-1:0] dotr  [3];
  cvom_mat_t          mat_q;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      prr[n] = pr_q[n] + (PrW'(1) <<< 29);
    end
    pos[0] = $signed(itm_q[1].cam_x);
    pos[1] = $signed(itm_q[1].cam_y);
    pos[2] = $signed(itm_q[1].cam_z);
    for (int r = 0; r < 3; r++) begin
      dotr[r] = dot_q[r] + DotW'(32768);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    itm_q[0] <= item_i;
    for (int s = 1; s < Depth; s++) begin
      itm_q[s] <= itm_q[s-1];
    end
    pr_q[0] <= sin_yaw_i * sin_pitch_i;
    pr_q[1] <= cos_yaw_i * sin_pitch_i;
    pr_q[2] <= sin_yaw_i * cos_pitch_i;
    pr_q[3] <= cos_yaw_i * cos_pitch_i;
    sy_q <= sin_yaw_i;
    cy_q <= cos_yaw_i;
    sp_q <= sin_pitch_i;
    cp_q <= cos_pitch_i;

    rot_q[0][0] <= cy_q;
    rot_q[0][1] <= '0;
    rot_q[0][2] <= -sy_q;
    rot_q[1][0] <= prr[0][XyW+29:30];
    rot_q[1][1] <= cp_q;
    rot_q[1][2] <= prr[1][XyW+29:30];
    rot_q[2][0] <= prr[2][XyW+29:30];
    rot_q[2][1] <= -sp_q;
    rot_q[2][2] <= prr[3][XyW+29:30];

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        dp_q[r][c]   <= rot_q[r][c] * pos[c];
        rot3_q[r][c] <= rot_q[r][c];
        rot4_q[r][c] <= rot3_q[r][c];
      end
      dot_q[r] <= DotW'(dp_q[r][0]) + DotW'(dp_q[r][1]) + DotW'(dp_q[r][2]);
      for (int c = 0; c < 3; c++) begin
        mat_q[r*4+c] <= VW'(rot4_q[r][c]);
      end
      mat_q[r*4+3] <= -dotr[r][VW+15:16];
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign item_o  = itm_q[Depth-1];
  assign mat_o   = mat_q;

endmodule

`default_nettype wire

// ===== sv/cvom_div.sv =====
// ----------------------------------------------------------------------------
// cvom_div
// Pipelined scaling divider: one quotient bit per stage, rounding to nearest,
// ties away from zero, then saturation to signed Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module cvom_div import cvom_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [VW-1:0]    v_i,
  input  cvom_tag_t        tag_i,
  input  logic [31:0]      w_i,
  input  logic [15:0]      asp_i,
  input  logic [15:0]      fd_i,
  output logic             valid_o,
  output cvom_out_t        out_o
);

  localparam int Depth = QW + 3;
  localparam logic signed [QW+1:0] EntMax = (QW+2)'(64'sd2147483647);
  localparam logic signed [QW+1:0] EntMin = -(QW+2)'(64'sd2147483648);
  localparam logic signed [QW+1:0] OneQ16 = (QW+2)'(65536);

  logic [Depth-1:0]       vld_q;
  cvom_tag_t              tag_q [Depth];
  logic signed [NumW-1:0] vext, num_d, num_q;
  logic [DenW-1:0]        den_d, den_q, den1_q;
  logic [NumW-1:0]        t_q;
  logic                   neg1_q;
  logic [QW+1:0]          hi;
  logic                   ovf;
  logic [RemW-1:0]        rem_q  [QW+1];
  logic [QW-1:0]          low_q  [QW+1];
  logic [QW-1:0]          q_q    [QW+1];
  logic [DenW-1:0]        denp_q [QW+1];
  logic                   negp_q [QW+1];
  logic                   ovfp_q [QW+1];
  logic [RemW-1:0]        rs     [QW];
  logic                   ge     [QW];
  logic signed [QW+1:0]   e;
  logic signed [31:0]     sat;
  logic                   vld_out_q;
  cvom_out_t              out_q;
  cvom_tag_t              tl;

  always_comb begin
    vext = {{(NumW-VW){v_i[VW-1]}}, v_i};
    case (tag_i.row)
      2'd0: begin
        num_d = vext <<< 3;
        den_d = {5'b0, w_i};
      end
      2'd1: begin
        num_d = $signed(v_i) * $signed({1'b0, asp_i});
        den_d = {w_i, 5'b0};
      end
      default: begin
        num_d = vext;
        den_d = {8'b0, fd_i, 13'b0};
      end
    endcase
  end

  always_comb begin
    hi  = t_q[NumW-1:QW];
    ovf = {2'b0, hi} >= den1_q;
    for (int k = 0; k < QW; k++) begin
      rs[k] = {rem_q[k][RemW-2:0], low_q[k][QW-1]};
      ge[k] = rs[k] >= {1'b0, denp_q[k]};
    end
    e = negp_q[QW] ? -$signed({2'b0, q_q[QW]}) : $signed({2'b0, q_q[QW]});
    tl = tag_q[Depth-1];
    if (tl.addone) begin
      e = e + OneQ16;
    end
    if (ovfp_q[QW]) begin
      sat = negp_q[QW] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (e > EntMax) begin
      sat = 32'sh7fffffff;
    end else if (e < EntMin) begin
      sat = 32'sh80000000;
    end else begin
      sat = e[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[Depth-2:0], valid_i};
      vld_out_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int s = 1; s < Depth; s++) begin
      tag_q[s] <= tag_q[s-1];
    end
    num_q  <= num_d;
    den_q  <= den_d;
    neg1_q <= num_q[NumW-1];
    t_q    <= (num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q)) + NumW'(den_q >> 1);
    den1_q <= den_q;

    rem_q[0]  <= ovf ? '0 : {3'b0, hi};
    low_q[0]  <= t_q[QW-1:0];
    q_q[0]    <= '0;
    denp_q[0] <= den1_q;
    negp_q[0] <= neg1_q;
    ovfp_q[0] <= ovf;
    for (int k = 0; k < QW; k++) begin
      rem_q[k+1]  <= ge[k] ? rs[k] - {1'b0, denp_q[k]} : rs[k];
      low_q[k+1]  <= low_q[k] << 1;
      q_q[k+1]    <= {q_q[k][QW-2:0], ge[k]};
      denp_q[k+1] <= denp_q[k];
      negp_q[k+1] <= negp_q[k];
      ovfp_q[k+1] <= ovfp_q[k];
    end

    out_q.row_index    <= tl.row;
    out_q.col_index    <= tl.col;
    out_q.entry_value  <= tl.byp ? tl.byp_val : sat;
    out_q.divide_error <= tl.err;
    out_q.last_entry   <= tl.last;
  end

  assign valid_o = vld_out_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ===== sv/camera_view_ortho_matrix.sv =====
// ----------------------------------------------------------------------------
// camera_view_ortho_matrix
// Combined view and orthographic projection matrix from one camera word.
// ----------------------------------------------------------------------------
// A camera word is taken when start_i is high and busy_o is low; busy_o then
// stays high for as long as the output serialiser needs to emit the sixteen
// entries, one per cycle, in row-major order, before another word is taken.
// Each word passes through the CORDIC, rotation, serialiser and divider.
// The receiver cannot stall: each entry is on entry_o for one cycle with
// entry_valid_o high. far_depth is written through cfg_valid_i/cfg_data_i,
// which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_view_ortho_matrix import cvom_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  cvom_in_t    cam_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        entry_valid_o,
  output cvom_out_t   entry_o
);

  logic        accept;
  logic [3:0]  cool_d, cool_q;
  logic [15:0] far_q, fd;
  logic        cor_vld, rot_vld;
  cvom_in_t    cor_itm, rot_itm;
  xy_t         sy, cy, sp, cp;
  cvom_mat_t   rot_mat, mat_q;
  logic [31:0] w_q;
  logic [15:0] asp_q;
  logic        err_q;
  logic        act_d, act_q;
  logic [3:0]  k_d, k_q;
  logic [3:0]  sel;
  cvom_tag_t   tag;

  assign accept      = start_i && !busy_o;
  assign busy_o      = cool_q != '0;
  assign cfg_ready_o = 1'b1;
  assign fd          = (far_q == '0) ? 16'd1 : far_q;

  always_comb begin
    if (accept) begin
      cool_d = 4'(EntryCount - 1);
    end else if (cool_q != '0) begin
      cool_d = cool_q - 4'd1;
    end else begin
      cool_d = cool_q;
    end
    act_d = act_q;
    k_d   = k_q;
    if (rot_vld) begin
      act_d = 1'b1;
      k_d   = '0;
    end else if (act_q) begin
      k_d = k_q + 4'd1;
      if (k_q == 4'(EntryCount - 1)) begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_q <= '0;
      far_q  <= 16'd64;
      act_q  <= 1'b0;
      k_q    <= '0;
    end else begin
      cool_q <= cool_d;
      act_q  <= act_d;
      k_q    <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        far_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_vld) begin
      mat_q <= rot_mat;
      w_q   <= rot_itm.view_width;
      asp_q <= rot_itm.view_aspect;
      err_q <= (rot_itm.view_width == '0) || (rot_itm.view_aspect == '0);
    end
  end

  always_comb begin
    sel         = (k_q < 4'd12) ? k_q : 4'd0;
    tag.row     = k_q[3:2];
    tag.col     = k_q[1:0];
    tag.byp     = err_q || (k_q[3:2] == 2'd3);
    tag.byp_val = (!err_q && k_q == 4'(EntryCount - 1)) ? 32'sd65536 : 32'sd0;
    tag.err     = err_q;
    tag.last    = k_q == 4'(EntryCount - 1);
    tag.addone  = (k_q[3:2] == 2'd2) && (k_q[1:0] == 2'd3);
  end

  cvom_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .item_i      (cam_i),
    .valid_o     (cor_vld),
    .item_o      (cor_itm),
    .sin_yaw_o   (sy),
    .cos_yaw_o   (cy),
    .sin_pitch_o (sp),
    .cos_pitch_o (cp)
  );

  cvom_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cor_vld),
    .item_i      (cor_itm),
    .sin_yaw_i   (sy),
    .cos_yaw_i   (cy),
    .sin_pitch_i (sp),
    .cos_pitch_i (cp),
    .valid_o     (rot_vld),
    .item_o      (rot_itm),
    .mat_o       (rot_mat)
  );

  cvom_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (act_q),
    .v_i     (mat_q[sel]),
    .tag_i   (tag),
    .w_i     (w_q),
    .asp_i   (asp_q),
    .fd_i    (fd),
    .valid_o (entry_valid_o),
    .out_o   (entry_o)
  );

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("busy_o not raised after a word was taken");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_vld |-> (!act_q || k_q == 4'(EntryCount - 1)))
    else $error("new matrix arrived while entries still pending");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && !entry_o.last_entry) |=> entry_valid_o)
    else $error("entry burst broken");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && entry_o.divide_error) |-> (entry_o.entry_value == '0))
    else $error("non-zero entry with divide_error");

endmodule

`default_nettype wire

// ===== tb/camera_view_ortho_matrix_test.sv =====
// ----------------------------------------------------------------------------
// camera_view_ortho_matrix_test
// Self-checking bench for the camera view / orthographic matrix block.
// ----------------------------------------------------------------------------
// Directed camera words first (extremes, angle wrap, zero width and aspect),
// then random words in three phases with different far_depth settings and
// sender gaps. Every entry is checked against a fixed-point matrix builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_view_ortho_matrix_test;
  import cvom_pkg::*;

  localparam int     WatchdogLimit = 4000;
  localparam int     DrainCycles   = 100;
  localparam longint Q30Pi64       = 64'sd3373259426;
  localparam longint Q30HalfPi64   = 64'sd1686629713;
  localparam longint Gain64        = 64'sd652032874;
  localparam longint Q16One        = 64'sd65536;

  typedef struct {
    cvom_in_t cam;
    bit       zero_matrix;
  } cam_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  cvom_in_t    cam_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        entry_valid_o;
  cvom_out_t   entry_o;

  cvom_out_t   pending_entries[$];
  logic [15:0] far_depth_q = 16'd64;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          send_gap_pct = 0;
  cam_row_t    stim_rows[$];

  camera_view_ortho_matrix dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cam_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .entry_valid_o, .entry_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void sin_cos(input longint ang13, output longint s, output longint c);
    longint atan_q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
      8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    longint a, x, y, nx;
    bit     flip;
    a = ang13 * 131072;
    x = Gain64;
    y = 0;
    flip = 1'b0;
    if (a > Q30Pi64) a -= 2 * Q30Pi64;
    else if (a < -Q30Pi64) a += 2 * Q30Pi64;
    if (a > Q30HalfPi64) begin
      a = Q30Pi64 - a;
      flip = 1'b1;
    end else if (a < -Q30HalfPi64) begin
      a = -Q30Pi64 - a;
      flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= atan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += atan_q30[i];
      end
      x = nx;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint div_nearest(input longint num, input longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + longint'(den) / 2) / longint'(den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void push_matrix(input cvom_in_t c, input logic [15:0] far_depth);
    longint    sy, cy, sp, cp, w, asp, fd, dot, e;
    longint    p[3];
    longint    rot[3][3];
    longint    v[4];
    logic signed [31:0] m[4][4];
    bit        err;
    cvom_out_t o;
    w   = c.view_width;
    asp = c.view_aspect;
    fd  = (far_depth == 0) ? 1 : far_depth;
    err = (w == 0) || (asp == 0);
    p[0] = c.cam_x;
    p[1] = c.cam_y;
    p[2] = c.cam_z;
    sin_cos(c.cam_yaw, sy, cy);
    sin_cos(c.cam_pitch, sp, cp);
    rot[0][0] = cy;               rot[0][1] = 0;   rot[0][2] = -sy;
    rot[1][0] = mul_q30(sy, sp);  rot[1][1] = cp;  rot[1][2] = mul_q30(cy, sp);
    rot[2][0] = mul_q30(sy, cp);  rot[2][1] = -sp; rot[2][2] = mul_q30(cy, cp);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) m[i][j] = '0;
    if (!err) begin
      for (int i = 0; i < 3; i++) begin
        dot = 0;
        for (int j = 0; j < 3; j++) begin
          v[j] = rot[i][j];
          dot += rot[i][j] * p[j];
        end
        v[3] = -((dot + 32768) >>> 16);
        for (int j = 0; j < 4; j++) begin
          if (i == 0) e = div_nearest(v[j] * 8, w);
          else if (i == 1) e = div_nearest(v[j] * asp, 32 * w);
          else e = div_nearest(v[j], 8192 * fd);
          if (i == 2 && j == 3) e += Q16One;
          m[i][j] = sat32(e);
        end
      end
      m[3][3] = 32'sd65536;
    end
    for (int k = 0; k < 16; k++) begin
      o.row_index    = k[3:2];
      o.col_index    = k[1:0];
      o.entry_value  = m[k / 4][k % 4];
      o.divide_error = err;
      o.last_entry   = (k == 15);
      pending_entries.push_back(o);
    end
  endfunction

  task automatic report_mismatch(input string what, input cvom_out_t got, input cvom_out_t exp);
    $display("mismatch %s: got r%0d c%0d %h err %b last %b, exp r%0d c%0d %h err %b last %b",
             what, got.row_index, got.col_index, got.entry_value, got.divide_error,
             got.last_entry, exp.row_index, exp.col_index, exp.entry_value,
             exp.divide_error, exp.last_entry);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    cvom_out_t exp;
    if (entry_valid_o) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected entry", entry_o, '0);
      end else begin
        exp = pending_entries.pop_front();
        if (entry_o !== exp) report_mismatch("entry", entry_o, exp);
      end
    end
  end

  always @(posedge clk_i) begin
    if (entry_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("camera_view_ortho_matrix test failed");
      $finish;
    end
  end

  task automatic send_camera(input cvom_in_t c, input bit zero_matrix);
    cvom_out_t o;
    bit        idle;
    forever begin
      idle = ($urandom_range(99) < send_gap_pct);
      start_i <= !idle;
      cam_i   <= c;
      @(posedge clk_i);
      if (!idle && !busy_o) break;
    end
    if (zero_matrix) begin
      for (int k = 0; k < 16; k++) begin
        o = '{row_index: k[3:2], col_index: k[1:0], entry_value: '0,
              divide_error: 1'b1, last_entry: (k == 15)};
        pending_entries.push_back(o);
      end
    end else begin
      push_matrix(c, far_depth_q);
    end
  endtask

  task automatic set_far_depth(input logic [15:0] value);
    start_i <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    far_depth_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0:       return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic cvom_in_t rand_camera();
    cvom_in_t c;
    c.cam_x     = rand_pos();
    c.cam_y     = rand_pos();
    c.cam_z     = rand_pos();
    c.cam_yaw   = 16'($signed($urandom_range(0, 51472)) - 25736);
    c.cam_pitch = 16'($signed($urandom_range(0, 51472)) - 25736);
    case ($urandom_range(9))
      0:       c.view_width = 32'd0;
      1, 2:    c.view_width = $urandom;
      default: c.view_width = $urandom_range(1 << 12, 1 << 24);
    endcase
    case ($urandom_range(9))
      0:       c.view_aspect = 16'd0;
      1, 2:    c.view_aspect = 16'($urandom);
      default: c.view_aspect = 16'($urandom_range(64, 1024));
    endcase
    return c;
  endfunction

  function automatic void add_row(input logic [31:0] x, y, z, input logic [15:0] yaw, pitch,
                                  input logic [31:0] w, input logic [15:0] asp,
                                  input bit zero_matrix);
    cam_row_t r;
    r.cam = '{cam_x: x, cam_y: y, cam_z: z, cam_yaw: yaw, cam_pitch: pitch,
              view_width: w, view_aspect: asp};
    r.zero_matrix = zero_matrix;
    stim_rows.push_back(r);
  endfunction

  initial begin
    add_row(0, 0, 0, 0, 0, 32'h0001_0000, 16'h0100, 1'b0);
    add_row(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 16'd6434, 16'hf9de,
            32'h0008_0000, 16'h01c7, 1'b0);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'd25736, 16'd25736,
            32'd1, 16'hffff, 1'b0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd25736, -16'sd25736,
            32'hffff_ffff, 16'd1, 1'b0);
    add_row(32'h8000_0000, 32'h7fff_ffff, 0, 16'd12868, -16'sd12868,
            32'h0000_0100, 16'h0100, 1'b0);
    add_row(32'h1234_5678, 32'h0, 32'h0, 16'd25735, -16'sd25735, 32'h0010_0000,
            16'h0080, 1'b0);
    add_row(32'h0, 32'h0, 32'h0, 16'd20000, -16'sd20000, 32'h0001_0000, 16'h0100, 1'b0);
    add_row(32'h0005_0000, 32'h0, 32'h0, 0, 0, 32'd0, 16'h0100, 1'b1);
    add_row(32'h0005_0000, 32'h0, 32'h0, 16'd100, 0, 32'h0001_0000, 16'd0, 1'b1);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'd25736, 0, 32'd0, 16'd0, 1'b1);
    add_row(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 16'hffff, 16'h0001,
            32'h8000_0000, 16'h8000, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_camera(stim_rows[i].cam, stim_rows[i].zero_matrix);
    set_far_depth(16'd65535);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd8000, -16'sd8000,
            32'h0000_0001, 16'hffff, 1'b0);
    send_camera(stim_rows[$].cam, 1'b0);
    set_far_depth(16'd0);
    send_camera(stim_rows[2].cam, 1'b0);
    send_camera(stim_rows[1].cam, 1'b0);

    set_far_depth(16'd1);
    send_gap_pct = 32;
    repeat (120) send_camera(rand_camera(), 1'b0);

    set_far_depth(16'($urandom_range(2, 65534)));
    send_gap_pct = 82;
    repeat (110) send_camera(rand_camera(), 1'b0);

    set_far_depth(16'd65535);
    send_gap_pct = 0;
    repeat (120) send_camera(rand_camera(), 1'b0);

    start_i <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("camera_view_ortho_matrix test passed");
    else
      $display("camera_view_ortho_matrix test failed");
    $finish;
  end

endmodule
